// ----- hw/rtl/gjk_pkg.sv -----
// ----------------------------------------------------------------------------
// GJK simplex update - shared types and constants
// Field widths, status and operation codes, sequencer states and the
// saturation of a search direction to the result width.
// ----------------------------------------------------------------------------
package gjk_pkg;

    localparam int BIG_W      = 64;
    localparam int HALF_W     = 32;
    localparam int FIELD_W    = 16;
    localparam int IN_DATA_W  = 48;
    localparam int DIR_W      = 53;
    localparam int SIZE_W     = 3;
    localparam int OUT_DATA_W = 168;
    localparam int ITER_W     = 8;

    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd50;
    localparam logic [ITER_W-1:0] ITER_SAT       = 8'd255;

    typedef logic signed [BIG_W-1:0] big_t;
    typedef logic signed [DIR_W-1:0] dir_t;

    typedef enum logic [1:0]
    {
        ST_CONTINUE  = 2'd0,
        ST_SEPARATED = 2'd1,
        ST_INTERSECT = 2'd2,
        ST_LIMIT     = 2'd3
    } status_t;

    typedef enum logic
    {
        VU_CROSS = 1'b0,
        VU_DOT   = 1'b1
    } vu_op_t;

    typedef struct packed
    {
        logic   start;
        vu_op_t op;
    } vu_ctl_t;

    typedef struct packed
    {
        logic done;
        logic neg;
        logic zero;
    } vu_stat_t;

    typedef enum logic [3:0]
    {
        S_IDLE, S_SEP, S_LINE, S_FN, S_FD, S_C1, S_D1, S_TE1,
        S_TE2, S_C2, S_D2, S_TD, S_ED1, S_ED2, S_STEP, S_OUT
    } state_t;

    typedef enum logic [2:0]
    {
        SV_AB, SV_AC, SV_AD, SV_AO, SV_P
    } small_sel_t;

    typedef enum logic [1:0]
    {
        U_DIR, U_N, U_T, U_SMALL
    } big_sel_t;

    function automatic dir_t sat_dir(input big_t v);
        logic [BIG_W-DIR_W:0] hi;
        dir_t                 r;
        hi = v[BIG_W-1:DIR_W-1];
        if ((&hi) || (~|hi))
            r = v[DIR_W-1:0];
        else if (v[BIG_W-1])
            r = {1'b1, {(DIR_W-1){1'b0}}};
        else
            r = {1'b0, {(DIR_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ----- hw/rtl/gjk_vec_unit.sv -----
// ----------------------------------------------------------------------------
// GJK vector unit
// Cross product or exact dot-product sign of a wide vector and a narrow
// vector, on one 33 x SMALL_W multiplier, each product in a low and a high half.
// ----------------------------------------------------------------------------
module gjk_vec_unit #(
    parameter int SMALL_W = 17
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gjk_pkg::vu_ctl_t          ctl,
    input  gjk_pkg::big_t             u_vec [3],
    input  logic signed [SMALL_W-1:0] v_vec [3],
    output gjk_pkg::vu_stat_t         stat,
    output gjk_pkg::big_t             res_vec [3]
);
    import gjk_pkg::*;

    localparam int PROD_W = HALF_W + 1 + SMALL_W;
    localparam int ACC_W  = BIG_W + SMALL_W + 2;
    localparam logic [3:0] CROSS_LAST = 4'd11;
    localparam logic [3:0] DOT_LAST   = 4'd5;

    logic                     busy_reg;
    vu_op_t                   op_reg;
    logic [3:0]               step_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     p_vld_reg;
    logic                     p_clear_reg;
    logic                     p_sub_reg;
    logic                     p_shift_reg;
    logic                     p_wr_reg;
    logic [1:0]               p_comp_reg;
    logic                     p_last_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic                     done_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    big_t                     res_reg [3];

    logic [2:0]               j;
    logic                     h;
    logic [1:0]               ui;
    logic [1:0]               vi;
    logic                     sub;
    logic                     clear;
    logic                     wr;
    logic                     last;
    logic signed [HALF_W:0]   a_part;
    logic signed [PROD_W-1:0] prod;
    big_t                     u_op;

    logic signed [ACC_W-1:0]  term_ext;
    logic signed [ACC_W-1:0]  term_sh;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  acc_next;

    assign j = step_reg[3:1];
    assign h = step_reg[0];

    always_comb
    begin
        ui    = 2'd0;
        vi    = 2'd0;
        sub   = 1'b0;
        clear = 1'b0;
        wr    = 1'b0;
        last  = 1'b0;
        if (op_reg == VU_CROSS)
        begin
            case (j)
                3'd0:
                begin
                    ui = 2'd1;
                    vi = 2'd2;
                end
                3'd1:
                begin
                    ui = 2'd2;
                    vi = 2'd1;
                end
                3'd2:
                begin
                    ui = 2'd2;
                    vi = 2'd0;
                end
                3'd3:
                begin
                    ui = 2'd0;
                    vi = 2'd2;
                end
                3'd4:
                begin
                    ui = 2'd0;
                    vi = 2'd1;
                end
                3'd5:
                begin
                    ui = 2'd1;
                    vi = 2'd0;
                end
                default:
                begin
                    ui = 2'd0;
                    vi = 2'd0;
                end
            endcase
            sub   = j[0];
            clear = !j[0] && !h;
            wr    = j[0] && h;
            last  = (step_reg == CROSS_LAST);
        end
        else
        begin
            ui    = j[1:0];
            vi    = j[1:0];
            clear = (step_reg == 4'd0);
            last  = (step_reg == DOT_LAST);
        end
    end

    assign u_op   = u_vec[ui];
    assign a_part = h ? {u_op[BIG_W-1], u_op[BIG_W-1:HALF_W]} : {1'b0, u_op[HALF_W-1:0]};
    assign prod   = a_part * v_vec[vi];

    assign term_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign term_sh  = p_shift_reg ? (term_ext <<< HALF_W) : term_ext;
    assign acc_base = p_clear_reg ? '0 : acc_reg;
    assign acc_next = p_sub_reg ? (acc_base - term_sh) : (acc_base + term_sh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            op_reg    <= VU_CROSS;
            step_reg  <= 4'd0;
            p_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            p_vld_reg <= busy_reg;
            done_reg  <= p_vld_reg && p_last_reg;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctl.op;
                step_reg <= 4'd0;
            end
            else if (busy_reg)
            begin
                if (last)
                    busy_reg <= 1'b0;
                else
                    step_reg <= step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod;
        p_clear_reg <= clear;
        p_sub_reg   <= sub;
        p_shift_reg <= h;
        p_wr_reg    <= wr;
        p_comp_reg  <= j[2:1];
        p_last_reg  <= last;
        if (p_vld_reg)
        begin
            acc_reg <= acc_next;
            if (p_wr_reg)
                res_reg[p_comp_reg] <= acc_next[BIG_W-1:0];
            if (p_last_reg)
            begin
                neg_reg  <= acc_next[ACC_W-1];
                zero_reg <= (acc_next == '0);
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.neg  = neg_reg;
    assign stat.zero = zero_reg;
    assign res_vec   = res_reg;

endmodule

// ----- hw/rtl/gjk_simplex_update.sv -----
// ----------------------------------------------------------------------------
// GJK simplex update
// One step of a 3-D GJK intersection query per support point request.
// ----------------------------------------------------------------------------
// A start request (tuser 0), or a continuing request with no query open, opens
// a query: the output state loads its result into the output register and the
// block then returns to idle for the next request. A continuing request runs
// the separation test and the line, triangle or tetrahedron reduction as a
// sequence of cross and dot products on one shared multiplier, which takes
// each 64 x (COORD_WIDTH+1) bit product in a low and a high half. The block
// takes no request while one is in work; a finished result waits in the
// output register and does not hold the next request back. Directions are
// exact integers in differing scales, saturated to 53 bits on the output only.
module gjk_simplex_update #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // point_x, point_y, point_z
    input  logic [gjk_pkg::IN_DATA_W-1:0]     s_tdata,
    // req_type
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // dir_x, dir_y, dir_z, simplex_size, zero fill
    output logic [gjk_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [gjk_pkg::ITER_W-1:0]        cfg_wr_data
);
    import gjk_pkg::*;

    localparam int SMALL_W = COORD_WIDTH + 1;
    localparam int PAD_W   = OUT_DATA_W - 3 * DIR_W - SIZE_W;

    state_t                         state_reg, state_next;
    logic                           issued_reg, issued_next;
    logic signed [COORD_WIDTH-1:0]  q_reg [4][3];
    logic signed [COORD_WIDTH-1:0]  q_next [4][3];
    logic signed [COORD_WIDTH-1:0]  p_reg [3];
    logic signed [COORD_WIDTH-1:0]  p_next [3];
    logic [2:0]                     cnt_reg, cnt_next;
    logic                           open_reg, open_next;
    logic [ITER_W-1:0]              iter_reg, iter_next;
    logic [ITER_W-1:0]              max_iter_reg;
    big_t                           dir_reg [3];
    big_t                           dir_next [3];
    big_t                           n_reg [3];
    big_t                           n_next [3];
    big_t                           t_reg [3];
    big_t                           t_next [3];
    logic [1:0]                     face_reg, face_next;
    logic                           enc_reg, enc_next;
    status_t                        status_reg, status_next;

    logic                           m_valid_reg, m_valid_next;
    dir_t                           m_dir_reg [3];
    dir_t                           m_dir_next [3];
    status_t                        m_status_reg, m_status_next;
    logic [SIZE_W-1:0]              m_size_reg, m_size_next;

    logic signed [COORD_WIDTH-1:0]  in_pt [3];
    logic signed [SMALL_W-1:0]      small_bank [5][3];
    big_t                           neg_a [3];
    big_t                           neg_n [3];
    logic [ITER_W-1:0]              limit;
    logic [ITER_W-1:0]              iter_inc;

    vu_ctl_t                        vu_ctl;
    vu_stat_t                       vu_stat;
    big_t                           vu_res [3];
    big_t                           u_vec [3];
    logic signed [SMALL_W-1:0]      v_vec [3];
    logic                           is_op;
    vu_op_t                         op_sel;
    big_sel_t                       u_sel;
    small_sel_t                     us_code;
    small_sel_t                     v_code;
    small_sel_t                     e1_code;
    small_sel_t                     e2_code;
    logic                           flip;
    logic                           pos;
    logic                           neg;

    always_comb
    begin
        for (int i = 0; i < COORD_WIDTH; i++)
        begin
            in_pt[0][i] = (i < FIELD_W) ? s_tdata[i] : 1'b0;
            in_pt[1][i] = (i < FIELD_W) ? s_tdata[FIELD_W + i] : 1'b0;
            in_pt[2][i] = (i < FIELD_W) ? s_tdata[2 * FIELD_W + i] : 1'b0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            small_bank[SV_AB][k] = {q_reg[1][k][COORD_WIDTH-1], q_reg[1][k]}
                                 - {q_reg[0][k][COORD_WIDTH-1], q_reg[0][k]};
            small_bank[SV_AC][k] = {q_reg[2][k][COORD_WIDTH-1], q_reg[2][k]}
                                 - {q_reg[0][k][COORD_WIDTH-1], q_reg[0][k]};
            small_bank[SV_AD][k] = {q_reg[3][k][COORD_WIDTH-1], q_reg[3][k]}
                                 - {q_reg[0][k][COORD_WIDTH-1], q_reg[0][k]};
            small_bank[SV_AO][k] = -{q_reg[0][k][COORD_WIDTH-1], q_reg[0][k]};
            small_bank[SV_P][k]  = {p_reg[k][COORD_WIDTH-1], p_reg[k]};
            neg_a[k] = -{{(BIG_W-COORD_WIDTH){q_reg[0][k][COORD_WIDTH-1]}}, q_reg[0][k]};
            neg_n[k] = -n_reg[k];
        end
    end

    assign e1_code = (face_reg == 2'd0) ? SV_AC : SV_AD;
    assign e2_code = (face_reg == 2'd1) ? SV_AC : SV_AB;
    assign flip    = (face_reg == 2'd2);
    assign pos     = !vu_stat.neg && !vu_stat.zero;
    assign neg     = vu_stat.neg;
    assign limit   = (max_iter_reg == '0) ? {{(ITER_W-1){1'b0}}, 1'b1} : max_iter_reg;
    assign iter_inc = (iter_reg == ITER_SAT) ? ITER_SAT : iter_reg + 1'b1;

    always_comb
    begin
        case (u_sel)
            U_DIR:   u_vec = dir_reg;
            U_N:     u_vec = n_reg;
            U_T:     u_vec = t_reg;
            default:
            begin
                for (int k = 0; k < 3; k++)
                    u_vec[k] = {{(BIG_W-SMALL_W){small_bank[us_code][k][SMALL_W-1]}},
                                small_bank[us_code][k]};
            end
        endcase
        v_vec = small_bank[v_code];
    end

    always_comb
    begin
        state_next    = state_reg;
        q_next        = q_reg;
        p_next        = p_reg;
        cnt_next      = cnt_reg;
        open_next     = open_reg;
        iter_next     = iter_reg;
        dir_next      = dir_reg;
        n_next        = n_reg;
        t_next        = t_reg;
        face_next     = face_reg;
        enc_next      = enc_reg;
        status_next   = status_reg;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;
        m_dir_next    = m_dir_reg;
        m_status_next = m_status_reg;
        m_size_next   = m_size_reg;
        is_op         = 1'b0;
        op_sel        = VU_DOT;
        u_sel         = U_DIR;
        us_code       = SV_AB;
        v_code        = SV_AO;
        s_tready      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    p_next = in_pt;
                    if (!s_tuser[0] || !open_reg || cnt_reg < 3'd1 || cnt_reg > 3'd3)
                    begin
                        q_next[0] = in_pt;
                        cnt_next  = 3'd1;
                        for (int k = 0; k < 3; k++)
                            dir_next[k] = -{{(BIG_W-COORD_WIDTH){in_pt[k][COORD_WIDTH-1]}},
                                            in_pt[k]};
                        iter_next   = '0;
                        open_next   = 1'b1;
                        status_next = ST_CONTINUE;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SEP;
                    end
                end
            end
            S_SEP:
            begin
                is_op  = 1'b1;
                u_sel  = U_DIR;
                v_code = SV_P;
                if (vu_stat.done)
                begin
                    if (neg)
                    begin
                        status_next = ST_SEPARATED;
                        open_next   = 1'b0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        q_next[3]  = q_reg[2];
                        q_next[2]  = q_reg[1];
                        q_next[1]  = q_reg[0];
                        q_next[0]  = p_reg;
                        cnt_next   = cnt_reg + 3'd1;
                        face_next  = 2'd0;
                        enc_next   = 1'b0;
                        state_next = (cnt_reg == 3'd1) ? S_LINE : S_FN;
                    end
                end
            end
            S_LINE:
            begin
                is_op   = 1'b1;
                u_sel   = U_SMALL;
                us_code = SV_AB;
                if (vu_stat.done)
                begin
                    if (pos)
                        state_next = S_ED1;
                    else
                    begin
                        cnt_next   = 3'd1;
                        dir_next   = neg_a;
                        state_next = S_STEP;
                    end
                end
            end
            S_FN:
            begin
                is_op  = 1'b1;
                op_sel = VU_CROSS;
                u_sel  = U_SMALL;
                case (face_reg)
                    2'd0:
                    begin
                        us_code = SV_AB;
                        v_code  = SV_AC;
                    end
                    2'd1:
                    begin
                        us_code = SV_AC;
                        v_code  = SV_AD;
                    end
                    default:
                    begin
                        us_code = SV_AD;
                        v_code  = SV_AB;
                    end
                endcase
                if (vu_stat.done)
                begin
                    n_next     = vu_res;
                    state_next = (cnt_reg == 3'd4) ? S_FD : S_C1;
                end
            end
            S_FD:
            begin
                is_op = 1'b1;
                u_sel = U_N;
                if (vu_stat.done)
                begin
                    if (pos)
                        state_next = S_C1;
                    else if (face_reg == 2'd2)
                    begin
                        enc_next   = 1'b1;
                        state_next = S_STEP;
                    end
                    else
                    begin
                        face_next  = face_reg + 2'd1;
                        state_next = S_FN;
                    end
                end
            end
            S_C1:
            begin
                is_op  = 1'b1;
                op_sel = VU_CROSS;
                u_sel  = U_N;
                v_code = e1_code;
                if (vu_stat.done)
                begin
                    t_next     = vu_res;
                    state_next = S_D1;
                end
            end
            S_D1:
            begin
                is_op = 1'b1;
                u_sel = U_T;
                if (vu_stat.done)
                begin
                    if (flip ? neg : pos)
                    begin
                        if (cnt_reg == 3'd4)
                        begin
                            q_next[1]  = (face_reg == 2'd0) ? q_reg[2] : q_reg[3];
                            cnt_next   = 3'd2;
                            state_next = S_ED1;
                        end
                        else
                            state_next = S_TE1;
                    end
                    else
                        state_next = S_C2;
                end
            end
            S_TE1:
            begin
                is_op   = 1'b1;
                u_sel   = U_SMALL;
                us_code = SV_AC;
                if (vu_stat.done)
                begin
                    if (pos)
                    begin
                        q_next[1]  = q_reg[2];
                        cnt_next   = 3'd2;
                        state_next = S_ED1;
                    end
                    else
                        state_next = S_TE2;
                end
            end
            S_TE2:
            begin
                is_op   = 1'b1;
                u_sel   = U_SMALL;
                us_code = SV_AB;
                if (vu_stat.done)
                begin
                    if (pos)
                    begin
                        cnt_next   = 3'd2;
                        state_next = S_ED1;
                    end
                    else
                    begin
                        cnt_next   = 3'd1;
                        dir_next   = neg_a;
                        state_next = S_STEP;
                    end
                end
            end
            S_C2:
            begin
                is_op  = 1'b1;
                op_sel = VU_CROSS;
                u_sel  = U_N;
                v_code = e2_code;
                if (vu_stat.done)
                begin
                    t_next     = vu_res;
                    state_next = S_D2;
                end
            end
            S_D2:
            begin
                is_op = 1'b1;
                u_sel = U_T;
                if (vu_stat.done)
                begin
                    if (flip ? pos : neg)
                    begin
                        if (cnt_reg == 3'd4)
                        begin
                            if (face_reg == 2'd1)
                                q_next[1] = q_reg[2];
                            cnt_next   = 3'd2;
                            state_next = S_ED1;
                        end
                        else
                            state_next = S_TE2;
                    end
                    else if (cnt_reg == 3'd4)
                    begin
                        if (face_reg == 2'd1)
                        begin
                            q_next[1] = q_reg[2];
                            q_next[2] = q_reg[3];
                        end
                        else if (face_reg == 2'd2)
                        begin
                            q_next[1] = q_reg[3];
                            q_next[2] = q_reg[1];
                        end
                        cnt_next   = 3'd3;
                        dir_next   = n_reg;
                        state_next = S_STEP;
                    end
                    else
                        state_next = S_TD;
                end
            end
            S_TD:
            begin
                is_op = 1'b1;
                u_sel = U_N;
                if (vu_stat.done)
                begin
                    if (pos)
                        dir_next = n_reg;
                    else
                    begin
                        q_next[1] = q_reg[2];
                        q_next[2] = q_reg[1];
                        dir_next  = neg_n;
                    end
                    state_next = S_STEP;
                end
            end
            S_ED1:
            begin
                is_op   = 1'b1;
                op_sel  = VU_CROSS;
                u_sel   = U_SMALL;
                us_code = SV_AB;
                v_code  = SV_AO;
                if (vu_stat.done)
                begin
                    t_next     = vu_res;
                    state_next = S_ED2;
                end
            end
            S_ED2:
            begin
                is_op  = 1'b1;
                op_sel = VU_CROSS;
                u_sel  = U_T;
                v_code = SV_AB;
                if (vu_stat.done)
                begin
                    dir_next   = vu_res;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                iter_next = iter_inc;
                if (enc_reg)
                begin
                    status_next = ST_INTERSECT;
                    open_next   = 1'b0;
                end
                else if (iter_inc >= limit)
                begin
                    status_next = ST_LIMIT;
                    open_next   = 1'b0;
                end
                else
                    status_next = ST_CONTINUE;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    for (int k = 0; k < 3; k++)
                        m_dir_next[k] = sat_dir(dir_reg[k]);
                    m_status_next = status_reg;
                    m_size_next   = cnt_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign vu_ctl.start = is_op && !issued_reg;
    assign vu_ctl.op    = op_sel;
    assign issued_next  = vu_stat.done ? 1'b0 : (vu_ctl.start ? 1'b1 : issued_reg);

    gjk_vec_unit #(
        .SMALL_W (SMALL_W)
    ) u_vec_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (vu_ctl),
        .u_vec   (u_vec),
        .v_vec   (v_vec),
        .stat    (vu_stat),
        .res_vec (vu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            issued_reg   <= 1'b0;
            cnt_reg      <= '0;
            open_reg     <= 1'b0;
            iter_reg     <= '0;
            max_iter_reg <= MAX_ITER_RESET;
            face_reg     <= '0;
            enc_reg      <= 1'b0;
            status_reg   <= ST_CONTINUE;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < 3; k++)
                dir_reg[k] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            cnt_reg    <= cnt_next;
            open_reg   <= open_next;
            iter_reg   <= iter_next;
            face_reg   <= face_next;
            enc_reg    <= enc_next;
            status_reg <= status_next;
            m_valid_reg <= m_valid_next;
            dir_reg    <= dir_next;
            if (cfg_wr_en)
                max_iter_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        t_reg        <= t_next;
        m_dir_reg    <= m_dir_next;
        m_status_reg <= m_status_next;
        m_size_reg   <= m_size_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_size_reg, m_dir_reg[2], m_dir_reg[1], m_dir_reg[0]};
    assign m_tuser  = m_status_reg;

`ifndef SYNTHESIS
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (cnt_reg != 3'd0 && cnt_reg <= 3'd4))
        else $error("open query with bad simplex size");
    a_intersect_size: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg == ST_INTERSECT) |-> (m_size_reg == 3'd4))
        else $error("intersection reported without a tetrahedron");
    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !issued_reg)
        else $error("request taken while the vector unit is in use");
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        vu_stat.done |-> issued_reg)
        else $error("vector unit result without an issued operation");
`endif

endmodule
